/* hdl/lph_pkg.sv */
// Package for the linear probe hash table: item layouts, codes and defaults.
// No dependencies.
package lph_pkg;

   localparam int DEF_TABLE_SIZE = 16;
   localparam int DEF_KEY_BITS   = 16;

   localparam int CMD_W      = 2;
   localparam int REQ_KEY_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_SEARCH   = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TAG_EMPTY   = 2'd0,
      TAG_DELETED = 2'd1,
      TAG_USED    = 2'd2
   } tag_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'd0,
      S_IDLE  = 3'd1,
      S_HASH  = 3'd2,
      S_PROBE = 3'd3,
      S_DONE  = 3'd4
   } state_type;

   typedef struct packed {
      logic    tag_we;
      logic    key_we;
      tag_type tag;
   } mem_wr_type;

endpackage

/* hdl/linear_probe_hash_table_core.sv */
// Top level of the linear probe hash table: control, probe sequencer, result register.
// Depends on lph_pkg, lph_hash and lph_mem.
//
//   channel | direction | tdata (lowest bit first)       | accepted on
//   req     | in        | command[1:0], key[17:2]        | req_tvalid & req_tready
//   rsp     | out       | status[1:0], position[5:2]     | rsp_tvalid & rsp_tready
//
// An item runs through the home slot remainder, then one tag/key memory read per cycle
// for each of the n slots probed (1 to TABLE_SIZE); the next item is accepted only once
// the block is back in idle. Command 3 skips the hash and the probe.
// After reset a clearing pass writes every tag, with req_tready low.
// A result waiting in the output register holds the block only when the next one is ready.
module linear_probe_hash_table_core import lph_pkg::*; #(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // command[1:0], key[17:2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], position[5:2]
);

   localparam int IDX_BITS = $clog2(TABLE_SIZE);
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_SIZE - 1);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [IDX_BITS-1:0]   probe_addr_ff, probe_addr_in;
   logic [IDX_BITS-1:0]   eval_addr_ff, eval_addr_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rdv_ff, rdv_in;
   status_type            res_status_ff, res_status_in;
   logic [IDX_BITS-1:0]   res_pos_ff, res_pos_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [REQ_KEY_W-1:0]  req_key, req_key_m;
   logic [KEY_BITS-1:0]   req_key_s;
   cmd_type               req_cmd;
   logic                  req_accept;
   logic                  slot_free;

   logic                  hash_start, hash_done;
   logic [IDX_BITS-1:0]   hash_home;

   mem_wr_type            mem_wr;
   logic [IDX_BITS-1:0]   wr_addr, rd_addr;
   logic [KEY_BITS-1:0]   wr_key, rd_key;
   tag_type               rd_tag;

   logic                  hit, empty, free, last;
   logic                  decide, dec_write, dec_key_we;
   tag_type               dec_tag;
   status_type            dec_status;
   logic                  rsp_load;
   status_type            ld_status;
   logic [IDX_BITS-1:0]   ld_pos;
   logic [POS_W-1:0]      ld_pos4;

   function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] a);
      next_idx = (a == IDX_LAST) ? '0 : a + IDX_BITS'(1);
   endfunction

   assign req_key    = req_tdata[CMD_W +: REQ_KEY_W];
   assign req_key_s  = KEY_BITS'({{KEY_BITS{1'b0}}, req_key});
   assign req_key_m  = REQ_KEY_W'({{REQ_KEY_W{1'b0}}, req_key_s});
   assign req_cmd    = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   lph_hash #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (req_key_m),
      .done (hash_done),
      .home (hash_home)
   );

   lph_mem #(
      .TABLE_SIZE(TABLE_SIZE),
      .KEY_BITS  (KEY_BITS)
   ) u_mem (
      .clock  (clock),
      .wr     (mem_wr),
      .wr_addr(wr_addr),
      .wr_key (wr_key),
      .rd_addr(rd_addr),
      .rd_tag (rd_tag),
      .rd_key (rd_key)
   );

   // probe evaluation on the slot read in the previous cycle
   always_comb begin
      hit        = rdv_ff && (rd_tag == TAG_USED) && (rd_key == key_ff);
      empty      = rdv_ff && (rd_tag == TAG_EMPTY);
      free       = empty || (rdv_ff && (rd_tag == TAG_DELETED));
      last       = rdv_ff && (cnt_ff == IDX_LAST);
      decide     = 1'b0;
      dec_write  = 1'b0;
      dec_key_we = 1'b0;
      dec_tag    = TAG_USED;
      dec_status = ST_MISSING;
      if (state_ff == S_PROBE && rdv_ff) begin
         if (cmd_ff == CMD_INSERT) begin
            if (free) begin
               decide     = 1'b1;
               dec_status = ST_OK;
               dec_write  = 1'b1;
               dec_key_we = 1'b1;
            end else if (hit) begin
               decide     = 1'b1;
               dec_status = ST_DUP;
            end else if (last) begin
               decide     = 1'b1;
               dec_status = ST_FULL;
            end
         end else begin
            if (hit) begin
               decide     = 1'b1;
               dec_status = ST_OK;
               if (cmd_ff == CMD_REMOVE) begin
                  dec_write = 1'b1;
                  dec_tag   = TAG_DELETED;
               end
            end else if (empty || last) begin
               decide     = 1'b1;
               dec_status = ST_MISSING;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (probe_addr_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_RESERVED) ? S_DONE : S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (decide) begin
               state_in = slot_free ? S_IDLE : S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      probe_addr_in = probe_addr_ff;
      eval_addr_in  = eval_addr_ff;
      cnt_in        = cnt_ff;
      rdv_in        = rdv_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      req_tready    = 1'b0;
      hash_start    = 1'b0;
      mem_wr.tag_we = 1'b0;
      mem_wr.key_we = 1'b0;
      mem_wr.tag    = dec_tag;
      wr_addr       = eval_addr_ff;
      wr_key        = key_ff;
      rd_addr       = probe_addr_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_wr.tag_we = 1'b1;
            mem_wr.tag    = TAG_EMPTY;
            wr_addr       = probe_addr_ff;
            probe_addr_in = next_idx(probe_addr_ff);
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               cmd_in        = req_cmd;
               key_in        = req_key_s;
               res_status_in = ST_MISSING;
               res_pos_in    = '0;
               hash_start    = (req_cmd != CMD_RESERVED);
            end
         end
         S_HASH: begin
            if (hash_done) begin
               probe_addr_in = hash_home;
               cnt_in        = '0;
               rdv_in        = 1'b0;
            end
         end
         S_PROBE: begin
            if (decide) begin
               rdv_in        = 1'b0;
               mem_wr.tag_we = dec_write;
               mem_wr.key_we = dec_key_we;
               res_status_in = dec_status;
               res_pos_in    = (dec_status == ST_OK) ? eval_addr_ff : '0;
               rsp_load      = slot_free;
            end else begin
               rdv_in        = 1'b1;
               eval_addr_in  = probe_addr_ff;
               probe_addr_in = next_idx(probe_addr_ff);
               if (rdv_ff) begin
                  cnt_in = cnt_ff + IDX_BITS'(1);
               end
            end
         end
         S_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      ld_status     = (state_ff == S_PROBE) ? res_status_in : res_status_ff;
      ld_pos        = (state_ff == S_PROBE) ? res_pos_in : res_pos_ff;
      ld_pos4       = POS_W'({{POS_W{1'b0}}, ld_pos});
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({ld_pos4, ld_status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         probe_addr_ff <= '0;
         cnt_ff        <= '0;
         rdv_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         probe_addr_ff <= probe_addr_in;
         cnt_ff        <= cnt_in;
         rdv_ff        <= rdv_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      eval_addr_ff  <= eval_addr_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      (mem_wr.tag_we || mem_wr.key_we) |-> (state_ff == S_PROBE || state_ff == S_CLEAR))
      else $error("slot memory written outside clear or probe");

   a_full_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && rdv_ff && cnt_ff == IDX_LAST) |-> decide)
      else $error("probe ran past a full pass");

   a_hash_done: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("home slot ready outside hash state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && ld_status != ST_OK) |=> (rsp_tdata_ff[STATUS_W +: POS_W] == '0))
      else $error("nonzero position on failed item");

endmodule

/* hdl/lph_hash.sv */
// Home slot unit: key mod TABLE_SIZE by reciprocal multiplication; the quotient is
// registered first, then the remainder from it. Depends on lph_pkg.
module lph_hash import lph_pkg::*; #(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [REQ_KEY_W-1:0]          key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home
);

   localparam int IDX_BITS    = $clog2(TABLE_SIZE);
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W      = REQ_KEY_W + RECIP_SHIFT;
   // ceil(2^32 / TABLE_SIZE): exact quotient for 16-bit keys
   localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(
      ((64'd1 << RECIP_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
   localparam logic [IDX_BITS-1:0] TS_LOW = IDX_BITS'(TABLE_SIZE);

   logic                  busy_ff, busy_in;
   logic                  phase_ff, phase_in;
   logic                  done_ff, done_in;
   logic [REQ_KEY_W-1:0]  key_ff, key_in;
   logic [IDX_BITS-1:0]   quot_ff, quot_in;
   logic [IDX_BITS-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]     prod;
   logic [IDX_BITS-1:0]   quot_ts;

   // remainder is below TABLE_SIZE, so the low index bits are enough
   always_comb begin
      prod    = PROD_W'(key_ff) * PROD_W'(RECIP);
      quot_ts = quot_ff * TS_LOW;
   end

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      key_in   = key_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         key_in   = key;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            quot_in  = prod[RECIP_SHIFT +: IDX_BITS];
            phase_in = 1'b1;
         end else begin
            rem_in  = key_ff[IDX_BITS-1:0] - quot_ts;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

/* hdl/lph_mem.sv */
// Slot storage: tag memory and key memory, one write and one read port each,
// registered read data. Depends on lph_pkg.
module lph_mem import lph_pkg::*; #(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic                          clock,
   input  mem_wr_type                    wr,
   input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output tag_type                       rd_tag,
   output logic [KEY_BITS-1:0]           rd_key
);

   tag_type             tag_mem_ff [TABLE_SIZE];
   logic [KEY_BITS-1:0] key_mem_ff [TABLE_SIZE];
   tag_type             rd_tag_ff;
   logic [KEY_BITS-1:0] rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr.tag_we) begin
         tag_mem_ff[wr_addr] <= wr.tag;
      end
      rd_tag_ff <= tag_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      rd_key_ff <= key_mem_ff[rd_addr];
   end

   assign rd_tag = rd_tag_ff;
   assign rd_key = rd_key_ff;

endmodule
